// ===== rtl/msarle_pkg.sv =====
// Shared types and constants for the MSA run-length track compressor.
// No dependencies; imported by every module of the block.
package msarle_pkg;

  localparam int LEN_W         = 16;
  localparam int BYTE_W        = 8;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] ESC_BYTE      = 8'hE5;
  localparam logic [LEN_W-1:0]  MIN_TOKEN_RUN = 16'd4;
  localparam logic [LEN_W-1:0]  MAX_RUN       = 16'hFFFF;
  localparam logic [LEN_W-1:0]  LIMIT_RESET   = 16'hFFFF;

  // One closed run handed from the run tracker to the emitter
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  len;
    logic              eot;   // run ends the track
  } job_t;

  typedef enum logic {
    BK_BYTES,
    BK_ERROR
  } bk_state_t;

endpackage

// ===== rtl/msarle_front.sv =====
// Run tracker: accepts track bytes, keeps the open run and emits closed runs.
// Depends on msarle_pkg.
module msarle_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [msarle_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                        s_tlast,     // end_of_track
  output logic                        job_valid,
  input  logic                        job_ready,
  output msarle_pkg::job_t            job
);
  import msarle_pkg::*;

  logic [BYTE_W-1:0] run_value;
  logic [LEN_W-1:0]  run_length;
  logic              pend_valid;
  job_t              pend_job;

  logic              accept;
  logic              flush_old;
  logic              need_first;
  logic [LEN_W-1:0]  new_len;
  job_t              old_job;
  job_t              eot_job;

  // Classify the incoming byte against the open run
  always_comb begin
    flush_old  = (run_length != '0) &&
                 ((s_tdata != run_value) || (run_length >= MAX_RUN));
    new_len    = (flush_old || (run_length == '0)) ? LEN_W'(1) : run_length + LEN_W'(1);
    old_job    = '{value: run_value, len: run_length, eot: 1'b0};
    eot_job    = '{value: s_tdata, len: new_len, eot: 1'b1};
    need_first = flush_old || s_tlast;
    s_tready   = !pend_valid && job_ready;
    accept     = s_tvalid && s_tready;
    if (pend_valid) begin
      job_valid = 1'b1;
      job       = pend_job;
    end else begin
      job_valid = accept && need_first;
      job       = flush_old ? old_job : eot_job;
    end
  end

  // Run state and the held second run of a two-flush item
  always_ff @(posedge clk) begin
    if (rst) begin
      run_value  <= '0;
      run_length <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && job_ready) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        run_value  <= s_tdata;
        run_length <= s_tlast ? '0 : new_len;
        if (flush_old && s_tlast) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && flush_old && s_tlast) begin
      pend_job <= eot_job;
    end
  end

endmodule

// ===== rtl/msarle_fifo.sv =====
// Short queue of closed runs between the run tracker and the emitter.
// Depends on msarle_pkg.
module msarle_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  msarle_pkg::job_t in_job,
  output logic             out_valid,
  input  logic             out_ready,
  output msarle_pkg::job_t out_job
);
  import msarle_pkg::*;

  job_t                entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != FIFO_CW'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_job;
    end
  end

endmodule

// ===== rtl/msarle_back.sv =====
// Emitter: turns closed runs into literals or escape tokens, checks the limit.
// Depends on msarle_pkg.
module msarle_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [msarle_pkg::LEN_W-1:0] cfg_data,
  input  logic                        job_valid,
  output logic                        job_pop,
  input  msarle_pkg::job_t            job,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,    // [7:0] out_byte, [23:8] total_length
  output logic                        m_tlast,    // last_of_track
  output logic                        m_tuser     // overflow
);
  import msarle_pkg::*;

  bk_state_t          state, state_next;
  logic [1:0]         idx, idx_next;
  logic [LEN_W-1:0]   bytes_out, bytes_out_next;
  logic               error_seen, error_seen_next;
  logic [LEN_W-1:0]   output_limit;

  logic               out_free;
  logic               tok;
  logic               fits4;
  logic               fits1;
  logic [LEN_W-1:0]   bytes_inc;
  logic [BYTE_W-1:0]  tok_byte;
  logic               job_done;
  logic               err_new;
  logic               emit;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_last;
  logic               emit_ovf;
  logic [LEN_W-1:0]   emit_total;

  assign cfg_ready = 1'b1;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      output_limit <= cfg_data;
    end
  end

  // Per-run sequencing, one output byte per cycle while the output register is free
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    bytes_out_next  = bytes_out;
    error_seen_next = error_seen;
    job_pop         = 1'b0;
    job_done        = 1'b0;
    err_new         = error_seen;
    emit            = 1'b0;
    emit_byte       = '0;
    emit_last       = 1'b0;
    emit_ovf        = 1'b0;
    emit_total      = bytes_out;

    out_free  = !m_tvalid || m_tready;
    tok       = (job.len >= MIN_TOKEN_RUN) || (job.value == ESC_BYTE);
    fits4     = ({1'b0, bytes_out} + 17'd4) <= {1'b0, output_limit};
    fits1     = ({1'b0, bytes_out} + 17'd1) <= {1'b0, output_limit};
    bytes_inc = bytes_out + LEN_W'(1);

    case (idx)
      2'd0:    tok_byte = ESC_BYTE;
      2'd1:    tok_byte = job.value;
      2'd2:    tok_byte = job.len[15:8];
      default: tok_byte = job.len[7:0];
    endcase

    unique case (state)
      BK_BYTES: begin
        if (job_valid && out_free) begin
          if (error_seen) begin
            job_done = 1'b1;
          end else if (tok) begin
            if ((idx == 2'd0) && !fits4) begin
              err_new  = 1'b1;
              job_done = 1'b1;
            end else begin
              emit      = 1'b1;
              emit_byte = tok_byte;
              job_done  = (idx == 2'd3);
            end
          end else begin
            if (!fits1) begin
              err_new  = 1'b1;
              job_done = 1'b1;
            end else begin
              emit      = 1'b1;
              emit_byte = job.value;
              job_done  = ((idx + 2'd1) == job.len[1:0]);
            end
          end
          if (emit) begin
            bytes_out_next = bytes_inc;
            emit_total     = bytes_inc;
            emit_last      = job.eot && job_done;
          end
          error_seen_next = err_new;
          idx_next        = job_done ? 2'd0 : idx + 2'd1;
          if (job_done) begin
            job_pop = 1'b1;
            if (job.eot) begin
              if (err_new) begin
                state_next = BK_ERROR;
              end else begin
                bytes_out_next  = '0;
                error_seen_next = 1'b0;
              end
            end
          end
        end
      end
      BK_ERROR: begin
        // Error end result closes the track
        if (out_free) begin
          emit            = 1'b1;
          emit_last       = 1'b1;
          emit_ovf        = 1'b1;
          emit_total      = bytes_out;
          bytes_out_next  = '0;
          error_seen_next = 1'b0;
          state_next      = BK_BYTES;
        end
      end
      default: state_next = BK_BYTES;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_BYTES;
      idx        <= '0;
      bytes_out  <= '0;
      error_seen <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      bytes_out  <= bytes_out_next;
      error_seen <= error_seen_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {emit_total, emit_byte};
      m_tlast <= emit_last;
      m_tuser <= emit_ovf;
    end
  end

endmodule

// ===== rtl/msa_rle_track_compressor.sv =====
// MSA run-length track compressor, top level.
// Depends on msarle_pkg, msarle_front, msarle_fifo, msarle_back.
//
// Usage:
//   s_* stream: one uncompressed track byte per transaction, tlast marks the
//   final byte of a track. m_* stream: one compressed byte per transaction;
//   tdata carries the byte and the running track length, tlast marks the end
//   of the track and tuser flags the overflow end result (byte then invalid).
//   cfg_*: writes the per-track output byte limit (reset 65535); write it only
//   while the block is idle.
// Flow:
//   A byte that extends the open run yields nothing. A run close yields up to
//   four bytes, one per cycle from the emitter while the receiver accepts;
//   an end-of-track byte that closes two runs queues both, the second held
//   in the run tracker. The first byte of a run passes through the run queue
//   and the output register before it appears on m_tvalid. A four-entry run
//   queue decouples intake from the emitter.
// Reset (synchronous, rst high) empties the queue, drops the output register
// and clears the open run. A stalled receiver holds the output register; the
// queue fills and then s_tready drops.
module msa_rle_track_compressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // end_of_track
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] out_byte, [23:8] total_length
  output logic        m_tlast,    // last_of_track
  output logic        m_tuser,    // overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // output_limit
);
  import msarle_pkg::*;

  logic  fr_valid;
  logic  fr_ready;
  job_t  fr_job;
  logic  q_valid;
  logic  q_pop;
  job_t  q_job;

  msarle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  msarle_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_job    (fr_job),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_job   (q_job)
  );

  msarle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job       (q_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
